/* sv/efc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efc_pkg
// Shared constants, register codes and transfer types of the floor controller.
// ----------------------------------------------------------------------------
package efc_pkg;

    localparam int NUM_FLOORS = 4;
    localparam int FLOOR_W    = 3;
    localparam int IDX_W      = $clog2(NUM_FLOORS);
    localparam int SLOT_W     = 4;
    localparam int MOVE_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 3;

    localparam logic [MOVE_W-1:0] MOVE_PERIOD_RESET = 16'd6000;
    localparam logic [BYTE_W-1:0] BYTE_PERIOD_RESET = 8'd40;
    localparam logic [7:0]        FRAME_OPEN        = 8'd9;
    localparam logic [7:0]        FRAME_CLOSE       = 8'd8;
    localparam logic [7:0]        DIR_UP_CODE       = 8'd2;
    localparam logic [7:0]        DIR_DOWN_CODE     = 8'd0;

    localparam logic [SLOT_W-1:0] SLOT_OPEN  = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_DIR   = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_FLOOR = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_GOAL  = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_REQ0  = 4'd4;
    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(NUM_FLOORS + 4);

    localparam logic REG_MOVE_PERIOD = 1'b0;
    localparam logic REG_BYTE_PERIOD = 1'b1;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic [MOVE_W-1:0] move_period;
        logic [BYTE_W-1:0] byte_period;
    } t_cfg;

    typedef struct packed {
        logic [FLOOR_W-1:0]    car_floor;
        logic [FLOOR_W-1:0]    target_floor;
        logic                  going_up;
        logic                  running;
        logic [NUM_FLOORS-1:0] request_lamps;
        logic                  byte_valid;
        logic [7:0]            byte_out;
    } t_result;

endpackage

/* sv/elevator_floor_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_floor_controller
// Four-floor scan controller, one tick item in and one status result out.
// ----------------------------------------------------------------------------
// Each pushed tick yields one result, popped in order. The block takes one
// tick per clock while its queues have room: a front stage picks the lowest
// pressed button, a two-entry queue holds classified ticks, and the back stage
// updates the car state and writes a two-entry result queue. A tick's result
// is registered in the tick queue, then in the result queue, before it reaches
// the result ports. The move and byte periods sit at byte addresses 0 and 4;
// the user must write them only while idle; the block does not enforce this.
module elevator_floor_controller import efc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [NUM_FLOORS-1:0] i_buttons_pressed,
    output logic                  empty,
    input  logic                  pop,
    output logic [FLOOR_W-1:0]    o_car_floor,
    output logic [FLOOR_W-1:0]    o_target_floor,
    output logic                  o_going_up,
    output logic                  o_running,
    output logic [NUM_FLOORS-1:0] o_request_lamps,
    output logic                  o_byte_valid,
    output logic [7:0]            o_byte_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_cfg    r_cfg;
    t_cmd    front_cmd;
    t_cmd    q_cmd;
    logic    q_valid;
    logic    q_pop;
    t_result result;
    logic    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.move_period <= MOVE_PERIOD_RESET;
            r_cfg.byte_period <= BYTE_PERIOD_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_MOVE_PERIOD: r_cfg.move_period <= pwdata[MOVE_W-1:0];
                REG_BYTE_PERIOD: r_cfg.byte_period <= pwdata[BYTE_W-1:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MOVE_PERIOD: prdata = 32'(r_cfg.move_period);
            REG_BYTE_PERIOD: prdata = 32'(r_cfg.byte_period);
            default:         prdata = '0;
        endcase
    end

    efc_front u_front (
        .i_buttons (i_buttons_pressed),
        .o_cmd     (front_cmd)
    );

    efc_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (q_pop)
    );

    efc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_empty     (empty),
        .o_result    (result),
        .i_pop       (pop)
    );

    assign o_car_floor     = result.car_floor;
    assign o_target_floor  = result.target_floor;
    assign o_going_up      = result.going_up;
    assign o_running       = result.running;
    assign o_request_lamps = result.request_lamps;
    assign o_byte_valid    = result.byte_valid;
    assign o_byte_out      = result.byte_out;

endmodule

/* sv/efc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efc_front
// Classifies a tick: finds the lowest pressed call button.
// ----------------------------------------------------------------------------
module efc_front import efc_pkg::*; (
    input  logic [NUM_FLOORS-1:0] i_buttons,
    output t_cmd                  o_cmd
);

    always_comb begin
        o_cmd = '0;
        for (int i = NUM_FLOORS - 1; i >= 0; i--) begin
            if (i_buttons[i]) begin
                o_cmd.hit = 1'b1;
                o_cmd.idx = IDX_W'(i);
            end
        end
    end

endmodule

/* sv/efc_cmd_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efc_cmd_fifo
// Two-entry queue of classified ticks between front and back.
// ----------------------------------------------------------------------------
module efc_cmd_fifo import efc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_data,
    input  logic i_pop
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       wr;
    logic       rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule

/* sv/efc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efc_back
// One tick per unstalled cycle: move step, status frame, latch, target scan.
// ----------------------------------------------------------------------------
module efc_back import efc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    o_empty,
    output t_result o_result,
    input  logic    i_pop
);

    logic [MOVE_W-1:0]     r_tick;
    logic [BYTE_W-1:0]     r_phase;
    logic [SLOT_W-1:0]     r_slot;
    logic [FLOOR_W-1:0]    r_floor;
    logic [FLOOR_W-1:0]    r_goal;
    logic                  r_up;
    logic                  r_run;
    logic [NUM_FLOORS-1:0] r_pend;

    logic [MOVE_W-1:0]     n_tick;
    logic [BYTE_W-1:0]     n_phase;
    logic [SLOT_W-1:0]     n_slot;
    logic [FLOOR_W-1:0]    n_floor;
    logic [FLOOR_W-1:0]    n_goal;
    logic                  n_up;
    logic                  n_run;
    logic [NUM_FLOORS-1:0] n_pend;

    t_result    r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       take;
    logic       out_pop;
    t_result    res;

    assign o_empty   = (r_cnt == 2'd0);
    assign o_result  = r_q[r_rp];
    assign out_pop   = i_pop && !o_empty;
    assign take      = i_cmd_valid && ((r_cnt != 2'd2) || out_pop);
    assign o_cmd_pop = take;

    always_comb begin
        logic [MOVE_W:0]       tick_inc;
        logic [BYTE_W:0]       ph_inc;
        logic                  moved;
        logic [IDX_W-1:0]      fidx;
        logic [IDX_W-1:0]      ridx;
        logic [NUM_FLOORS-1:0] scan;
        logic                  found;
        logic                  bvalid;
        logic [7:0]            bval;

        n_floor = r_floor;
        n_goal  = r_goal;
        n_up    = r_up;
        n_run   = r_run;
        n_pend  = r_pend;
        n_slot  = r_slot;
        bval    = 8'd0;
        found   = 1'b0;
        fidx    = '0;

        // move step
        tick_inc = {1'b0, r_tick} + (MOVE_W+1)'(1);
        moved    = (tick_inc >= {1'b0, i_cfg.move_period});
        n_tick   = moved ? '0 : tick_inc[MOVE_W-1:0];
        if (moved) begin
            if (r_run) begin
                if (r_up) begin
                    n_floor = (r_floor >= FLOOR_W'(NUM_FLOORS)) ?
                              FLOOR_W'(NUM_FLOORS) : r_floor + FLOOR_W'(1);
                end else begin
                    n_floor = (r_floor <= FLOOR_W'(1)) ?
                              FLOOR_W'(1) : r_floor - FLOOR_W'(1);
                end
                fidx = IDX_W'(n_floor - FLOOR_W'(1));
                if (r_goal == n_floor) begin
                    n_pend[fidx] = 1'b0;
                end
            end
            if (n_pend == '0) begin
                n_run = 1'b0;
                n_up  = ~r_up;
            end else begin
                n_run = 1'b1;
            end
        end

        // status frame
        ph_inc = {1'b0, r_phase} + (BYTE_W+1)'(1);
        if (moved || (ph_inc >= {1'b0, i_cfg.byte_period})) begin
            n_phase = '0;
        end else begin
            n_phase = ph_inc[BYTE_W-1:0];
        end
        bvalid = (n_phase == '0);
        ridx   = IDX_W'(r_slot - SLOT_REQ0);
        if (bvalid) begin
            case (r_slot)
                SLOT_OPEN:  bval = FRAME_OPEN;
                SLOT_DIR:   bval = n_up ? DIR_UP_CODE : DIR_DOWN_CODE;
                SLOT_FLOOR: bval = 8'(n_floor);
                SLOT_GOAL:  bval = 8'(r_goal);
                default: begin
                    bval = (r_slot < LAST_SLOT) ? 8'(n_pend[ridx]) : FRAME_CLOSE;
                end
            endcase
            n_slot = (r_slot >= LAST_SLOT) ? '0 : r_slot + SLOT_W'(1);
        end

        // button latch
        if (i_cmd.hit && (n_floor != FLOOR_W'(i_cmd.idx) + FLOOR_W'(1))) begin
            n_pend[i_cmd.idx] = 1'b1;
        end

        // target scan
        scan = n_pend;
        if (n_up) begin
            for (int i = 0; i < NUM_FLOORS; i++) begin
                if (!found && scan[i]) begin
                    found = 1'b1;
                    if (FLOOR_W'(i + 1) >= n_floor) begin
                        n_goal = FLOOR_W'(i + 1);
                    end else begin
                        n_pend[i] = 1'b0;
                    end
                end
            end
        end else begin
            for (int i = NUM_FLOORS - 1; i >= 0; i--) begin
                if (!found && scan[i]) begin
                    found = 1'b1;
                    if (FLOOR_W'(i + 1) <= n_floor) begin
                        n_goal = FLOOR_W'(i + 1);
                    end else begin
                        n_pend[i] = 1'b0;
                    end
                end
            end
        end

        res.car_floor     = n_floor;
        res.target_floor  = n_goal;
        res.going_up      = n_up;
        res.running       = n_run;
        res.request_lamps = n_pend;
        res.byte_valid    = bvalid;
        res.byte_out      = bval;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_phase <= '0;
            r_slot  <= '0;
            r_floor <= FLOOR_W'(1);
            r_goal  <= FLOOR_W'(1);
            r_up    <= 1'b1;
            r_run   <= 1'b0;
            r_pend  <= '0;
        end else if (take) begin
            r_tick  <= n_tick;
            r_phase <= n_phase;
            r_slot  <= n_slot;
            r_floor <= n_floor;
            r_goal  <= n_goal;
            r_up    <= n_up;
            r_run   <= n_run;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_q[r_wp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (take) begin
                r_wp <= ~r_wp;
            end
            if (out_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, take} - {1'b0, out_pop};
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue overflow");

    a_cnt_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !out_pop |=> r_cnt == 2'($past(r_cnt) + 2'd1))
        else $error("result not queued");

    a_floor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_floor >= FLOOR_W'(1) && r_floor <= FLOOR_W'(NUM_FLOORS) &&
        r_goal >= FLOOR_W'(1) && r_goal <= FLOOR_W'(NUM_FLOORS))
        else $error("floor out of range");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= LAST_SLOT)
        else $error("frame slot out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !take |=> $stable(r_floor) && $stable(r_run) && $stable(r_pend))
        else $error("state changed without a tick");
`endif

endmodule
